// ----- rtl/core/bsr_pkg.sv -----
// bsr_pkg: shared types, constants and codes of the banker's safety and request unit
// used by bsr_tables and bankers_safety_and_request; no dependencies
`default_nettype none
package bsr_pkg;

  localparam int PROCESS_SLOTS  = 8;
  localparam int RESOURCE_SLOTS = 4;
  localparam int COUNT_BITS     = 8;

  localparam int PIDX_BITS = $clog2(PROCESS_SLOTS);
  localparam int RIDX_BITS = (RESOURCE_SLOTS > 1) ? $clog2(RESOURCE_SLOTS) : 1;
  localparam int CNT_BITS  = $clog2(PROCESS_SLOTS + 1);
  localparam int RCNT_BITS = $clog2(RESOURCE_SLOTS + 1);
  // work vector grows by at most one full allocation row per process
  localparam int WORK_BITS = COUNT_BITS + $clog2(PROCESS_SLOTS + 1);
  localparam int CMP_BITS  = WORK_BITS + 1;
  localparam int REQ_BITS  = 8;
  localparam int REQ_FIELDS = 4;

  localparam int PCNT_REG_BITS = 4;
  localparam int RCNT_REG_BITS = 3;
  localparam int CFG_DATA_BITS = 4;

  typedef enum logic [0:0] {
    REG_PROCESS_COUNT  = 1'b0,
    REG_RESOURCE_COUNT = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    OP_LOAD_ALLOC = 3'd0,
    OP_LOAD_MAX   = 3'd1,
    OP_LOAD_AVAIL = 3'd2,
    OP_CHECK      = 3'd3,
    OP_REQUEST    = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_LOADED        = 3'd0,
    ST_SAFE          = 3'd1,
    ST_UNSAFE        = 3'd2,
    ST_EXCEEDS_NEED  = 3'd3,
    ST_UNAVAILABLE   = 3'd4,
    ST_GRANTED       = 3'd5,
    ST_DENIED_UNSAFE = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_REQ,
    S_SCAN,
    S_EMIT
  } state_t;

  typedef logic [RESOURCE_SLOTS-1:0][COUNT_BITS-1:0] row_t;

  typedef struct packed {
    logic [2:0] operation;
    logic [2:0] process_index;
    logic [1:0] resource_index;
    logic [7:0] load_value;
    logic [7:0] request_0;
    logic [7:0] request_1;
    logic [7:0] request_2;
    logic [7:0] request_3;
  } item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [2:0] sequence_process;
    logic       last;
  } result_t;

  // write port of the tables
  typedef struct packed {
    logic                      alloc_we;
    logic                      max_we;
    logic [PIDX_BITS-1:0]      row;
    logic [RESOURCE_SLOTS-1:0] lane_en;
    row_t                      data;
  } tbl_wr_t;

endpackage
`default_nettype wire

// ----- rtl/core/bsr_tables.sv -----
// bsr_tables: allocation and maximum tables, one row per process, registered read
// depends on bsr_pkg
`default_nettype none
module bsr_tables (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire bsr_pkg::tbl_wr_t              wr,
  input  wire logic [bsr_pkg::PIDX_BITS-1:0] rd_row,
  output bsr_pkg::row_t                      alloc_row,
  output bsr_pkg::row_t                      max_row
);

  bsr_pkg::row_t alloc_mem [bsr_pkg::PROCESS_SLOTS];
  bsr_pkg::row_t max_mem   [bsr_pkg::PROCESS_SLOTS];
  logic [bsr_pkg::RESOURCE_SLOTS-1:0] alloc_vld [bsr_pkg::PROCESS_SLOTS];
  logic [bsr_pkg::RESOURCE_SLOTS-1:0] max_vld   [bsr_pkg::PROCESS_SLOTS];
  bsr_pkg::row_t alloc_q, max_q;
  logic [bsr_pkg::RESOURCE_SLOTS-1:0] alloc_vq, max_vq;

  always_ff @(posedge clk) begin
    for (int r = 0; r < bsr_pkg::RESOURCE_SLOTS; r++) begin
      if (wr.alloc_we && wr.lane_en[r]) alloc_mem[wr.row][r] <= wr.data[r];
      if (wr.max_we && wr.lane_en[r]) max_mem[wr.row][r] <= wr.data[r];
    end
    alloc_q <= alloc_mem[rd_row];
    max_q   <= max_mem[rd_row];
  end

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < bsr_pkg::PROCESS_SLOTS; p++) begin
        alloc_vld[p] <= '0;
        max_vld[p]   <= '0;
      end
      alloc_vq <= '0;
      max_vq   <= '0;
    end else begin
      if (wr.alloc_we) alloc_vld[wr.row] <= alloc_vld[wr.row] | wr.lane_en;
      if (wr.max_we) max_vld[wr.row] <= max_vld[wr.row] | wr.lane_en;
      alloc_vq <= alloc_vld[rd_row];
      max_vq   <= max_vld[rd_row];
    end
  end

  always_comb begin
    for (int r = 0; r < bsr_pkg::RESOURCE_SLOTS; r++) begin
      alloc_row[r] = alloc_vq[r] ? alloc_q[r] : '0;
      max_row[r]   = max_vq[r] ? max_q[r] : '0;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/bankers_safety_and_request.sv -----
// bankers_safety_and_request: deadlock-avoidance unit, loads, safety check, requests
// a load is answered straight from idle; a check scans the tables, then emits the safe
// sequence, one result per process in use, or a single unsafe status; a request first
// checks need and availability; the scan evaluates one table row per cycle from the row memory
// one transaction at a time; results cannot be stalled; sync active-high reset
// clears tables to zero, process_count to 8 and resource_count to 4
`default_nettype none
module bankers_safety_and_request (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire bsr_pkg::item_t                    item,
  output logic                                   result_valid,
  output bsr_pkg::result_t                       result,
  input  wire logic                              cfg_we,
  input  wire logic                              cfg_index,
  input  wire logic [bsr_pkg::CFG_DATA_BITS-1:0] cfg_data
);

  localparam int PB = bsr_pkg::PIDX_BITS;
  localparam int RS = bsr_pkg::RESOURCE_SLOTS;
  localparam int CB = bsr_pkg::COUNT_BITS;
  localparam int NB = bsr_pkg::CNT_BITS;
  localparam int WB = bsr_pkg::WORK_BITS;
  localparam int MB = bsr_pkg::CMP_BITS;

  // config registers
  logic [bsr_pkg::PCNT_REG_BITS-1:0] process_count;
  logic [bsr_pkg::RCNT_REG_BITS-1:0] resource_count;
  logic [NB-1:0] np;
  logic [bsr_pkg::RCNT_BITS-1:0] nr;

  // sequencer state
  bsr_pkg::state_t state, state_next;
  logic req_mode, req_mode_next;
  logic [PB-1:0] pi_q, pi_q_next;
  logic [RS-1:0][bsr_pkg::REQ_BITS-1:0] req_q, req_q_next;
  bsr_pkg::row_t new_row, new_row_next;
  bsr_pkg::row_t avail, avail_next;
  logic [RS-1:0][WB-1:0] work, work_next;
  logic [bsr_pkg::PROCESS_SLOTS-1:0] done_mask, done_mask_next;
  logic [NB-1:0] count, count_next;
  logic [PB-1:0] cur_p, cur_p_next;
  logic progress, progress_next;
  logic [PB-1:0] k, k_next;
  logic result_valid_next;
  bsr_pkg::result_t result_next;

  // safe sequence store
  logic [PB-1:0] seq [bsr_pkg::PROCESS_SLOTS];
  logic seq_we;

  // table ports
  bsr_pkg::tbl_wr_t tbl_wr;
  logic [PB-1:0] rd_row;
  bsr_pkg::row_t alloc_row, max_row;

  bsr_tables u_tables (
    .clk      (clk),
    .rst      (rst),
    .wr       (tbl_wr),
    .rd_row   (rd_row),
    .alloc_row(alloc_row),
    .max_row  (max_row)
  );

  // effective counts: zero acts as one, clamp to slot count
  always_comb begin
    if (process_count == '0) np = NB'(1);
    else if (32'(process_count) > bsr_pkg::PROCESS_SLOTS) np = NB'(bsr_pkg::PROCESS_SLOTS);
    else np = NB'(process_count);
    if (resource_count == '0) nr = bsr_pkg::RCNT_BITS'(1);
    else if (32'(resource_count) > RS) nr = bsr_pkg::RCNT_BITS'(RS);
    else nr = bsr_pkg::RCNT_BITS'(resource_count);
  end

  assign busy = (state != bsr_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      process_count  <= bsr_pkg::PCNT_REG_BITS'(8);
      resource_count <= bsr_pkg::RCNT_REG_BITS'(4);
    end else if (cfg_we) begin
      unique case (bsr_pkg::reg_idx_t'(cfg_index))
        bsr_pkg::REG_PROCESS_COUNT:
          process_count <= bsr_pkg::PCNT_REG_BITS'(cfg_data);
        bsr_pkg::REG_RESOURCE_COUNT:
          resource_count <= bsr_pkg::RCNT_REG_BITS'(cfg_data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= bsr_pkg::S_IDLE;
      avail        <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      avail        <= avail_next;
      result_valid <= result_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    req_mode  <= req_mode_next;
    pi_q      <= pi_q_next;
    req_q     <= req_q_next;
    new_row   <= new_row_next;
    work      <= work_next;
    done_mask <= done_mask_next;
    count     <= count_next;
    cur_p     <= cur_p_next;
    progress  <= progress_next;
    k         <= k_next;
    result    <= result_next;
    if (seq_we) seq[count[PB-1:0]] <= cur_p;
  end

  always_comb begin
    logic [RS-1:0] lane_use;
    logic [RS-1:0][bsr_pkg::REQ_BITS-1:0] req_in;
    logic signed [MB-1:0] nd;
    logic signed [MB-1:0] rhs;
    logic fail_found;
    bsr_pkg::status_t fail_code;
    bsr_pkg::row_t a_eff;
    logic fits;
    logic [NB-1:0] cnt_new;
    logic last_p;

    state_next        = state;
    req_mode_next     = req_mode;
    pi_q_next         = pi_q;
    req_q_next        = req_q;
    new_row_next      = new_row;
    avail_next        = avail;
    work_next         = work;
    done_mask_next    = done_mask;
    count_next        = count;
    cur_p_next        = cur_p;
    progress_next     = progress;
    k_next            = k;
    result_valid_next = 1'b0;
    result_next       = result;
    seq_we            = 1'b0;
    tbl_wr            = '0;
    rd_row            = cur_p;
    fail_found        = 1'b0;
    fail_code         = bsr_pkg::ST_EXCEEDS_NEED;
    fits              = 1'b0;
    cnt_new           = count;
    last_p            = 1'b0;
    nd                = '0;
    rhs               = '0;

    for (int r = 0; r < RS; r++) begin
      lane_use[r] = (bsr_pkg::RCNT_BITS'(r) < nr);
      case (r)
        0: req_in[r] = item.request_0;
        1: req_in[r] = item.request_1;
        2: req_in[r] = item.request_2;
        3: req_in[r] = item.request_3;
        default: req_in[r] = '0;
      endcase
    end

    // the requesting process sees its tentative allocation during the scan
    a_eff = (req_mode && cur_p == pi_q) ? new_row : alloc_row;

    unique case (state)
      bsr_pkg::S_IDLE: begin
        if (start) begin
          pi_q_next  = item.process_index;
          req_q_next = req_in;
          result_next.sequence_process = '0;
          result_next.last = 1'b1;
          result_next.status = bsr_pkg::ST_LOADED;
          case (item.operation)
            bsr_pkg::OP_LOAD_ALLOC, bsr_pkg::OP_LOAD_MAX: begin
              result_valid_next = 1'b1;
              if (NB'(item.process_index) < np &&
                  bsr_pkg::RCNT_BITS'(item.resource_index) < nr) begin
                tbl_wr.alloc_we = (item.operation == bsr_pkg::OP_LOAD_ALLOC);
                tbl_wr.max_we   = (item.operation == bsr_pkg::OP_LOAD_MAX);
                tbl_wr.row      = item.process_index;
                tbl_wr.lane_en[item.resource_index] = 1'b1;
                tbl_wr.data[item.resource_index] = CB'(item.load_value);
              end
            end
            bsr_pkg::OP_LOAD_AVAIL: begin
              result_valid_next = 1'b1;
              if (bsr_pkg::RCNT_BITS'(item.resource_index) < nr)
                avail_next[item.resource_index] = CB'(item.load_value);
            end
            bsr_pkg::OP_CHECK: begin
              req_mode_next  = 1'b0;
              rd_row         = '0;
              cur_p_next     = '0;
              done_mask_next = '0;
              count_next     = '0;
              progress_next  = 1'b0;
              for (int r = 0; r < RS; r++) work_next[r] = WB'(avail[r]);
              state_next = bsr_pkg::S_SCAN;
            end
            bsr_pkg::OP_REQUEST: begin
              if (NB'(item.process_index) >= np) begin
                result_valid_next  = 1'b1;
                result_next.status = bsr_pkg::ST_EXCEEDS_NEED;
              end else begin
                rd_row        = item.process_index;
                req_mode_next = 1'b1;
                state_next    = bsr_pkg::S_REQ;
              end
            end
            default: result_valid_next = 1'b1;
          endcase
        end
      end

      bsr_pkg::S_REQ: begin
        // first failing resource in order decides the code
        for (int r = 0; r < RS; r++) begin
          nd  = $signed(MB'(max_row[r])) - $signed(MB'(alloc_row[r]));
          rhs = $signed(MB'(req_q[r]));
          if (lane_use[r] && !fail_found) begin
            if (rhs > nd) begin
              fail_found = 1'b1;
              fail_code  = bsr_pkg::ST_EXCEEDS_NEED;
            end else if (MB'(req_q[r]) > MB'(avail[r])) begin
              fail_found = 1'b1;
              fail_code  = bsr_pkg::ST_UNAVAILABLE;
            end
          end
        end
        if (fail_found) begin
          result_valid_next  = 1'b1;
          result_next.status = fail_code;
          state_next         = bsr_pkg::S_IDLE;
        end else begin
          for (int r = 0; r < RS; r++) begin
            new_row_next[r] = lane_use[r] ? CB'(alloc_row[r] + CB'(req_q[r])) : alloc_row[r];
            work_next[r]    = WB'(CB'(avail[r] - CB'(req_q[r])));
          end
          rd_row         = '0;
          cur_p_next     = '0;
          done_mask_next = '0;
          count_next     = '0;
          progress_next  = 1'b0;
          state_next     = bsr_pkg::S_SCAN;
        end
      end

      bsr_pkg::S_SCAN: begin
        // one process per cycle; next row is read while this one is evaluated
        fits = !done_mask[cur_p];
        for (int r = 0; r < RS; r++) begin
          nd  = $signed(MB'(max_row[r])) - $signed(MB'(a_eff[r]));
          rhs = $signed(MB'(work[r]));
          if (lane_use[r] && nd > rhs) fits = 1'b0;
        end
        if (fits) begin
          for (int r = 0; r < RS; r++)
            if (lane_use[r]) work_next[r] = work[r] + WB'(a_eff[r]);
          seq_we = 1'b1;
          done_mask_next[cur_p] = 1'b1;
          count_next    = count + NB'(1);
          progress_next = 1'b1;
        end
        cnt_new = fits ? count + NB'(1) : count;
        last_p  = (NB'(cur_p) == np - NB'(1));
        cur_p_next = last_p ? '0 : cur_p + PB'(1);
        rd_row     = cur_p_next;
        if (cnt_new == np) begin
          if (req_mode) begin
            tbl_wr.alloc_we = 1'b1;
            tbl_wr.row      = pi_q;
            tbl_wr.lane_en  = lane_use;
            tbl_wr.data     = new_row;
            for (int r = 0; r < RS; r++)
              if (lane_use[r]) avail_next[r] = CB'(avail[r] - CB'(req_q[r]));
          end
          k_next     = '0;
          state_next = bsr_pkg::S_EMIT;
        end else if (last_p) begin
          if (progress || fits) begin
            progress_next = 1'b0;
          end else begin
            result_valid_next  = 1'b1;
            result_next.status = req_mode ? bsr_pkg::ST_DENIED_UNSAFE : bsr_pkg::ST_UNSAFE;
            result_next.sequence_process = '0;
            result_next.last   = 1'b1;
            state_next         = bsr_pkg::S_IDLE;
          end
        end
      end

      bsr_pkg::S_EMIT: begin
        result_valid_next  = 1'b1;
        result_next.status = req_mode ? bsr_pkg::ST_GRANTED : bsr_pkg::ST_SAFE;
        result_next.sequence_process = 3'(seq[k]);
        result_next.last   = (NB'(k) == count - NB'(1));
        k_next = k + PB'(1);
        if (NB'(k) == count - NB'(1)) state_next = bsr_pkg::S_IDLE;
      end

      default: state_next = bsr_pkg::S_IDLE;
    endcase
  end

  // the scan never finishes more processes than are in use
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (state == bsr_pkg::S_SCAN || state == bsr_pkg::S_EMIT) |-> count <= np)
    else $error("finished count beyond process count");

  // the final result of a transaction leaves the unit free
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.last) |-> !busy)
    else $error("busy after final result");

  // only the sequence output streams several results
  a_mid_emit: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.last) |-> (state == bsr_pkg::S_EMIT))
    else $error("non-final result outside sequence output");

  // an accepted check always makes the unit busy
  a_check_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.operation == bsr_pkg::OP_CHECK) |=> busy)
    else $error("safety check did not start");

endmodule
`default_nettype wire

// ----- sim/bsr_checker.sv -----
// bsr_checker: watches the item, config and result channels of the banker's unit,
// predicts every result and compares field by field; depends on bsr_pkg
`timescale 1ns / 100ps
module bsr_checker
  import bsr_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic                     busy,
  input  item_t                    item,
  input  logic                     result_valid,
  input  result_t                  result,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  output int                       errors,
  output int                       pending,
  output int                       results_seen
);

  typedef logic [PROCESS_SLOTS-1:0][RESOURCE_SLOTS-1:0][COUNT_BITS-1:0] table_t;
  typedef logic [PROCESS_SLOTS-1:0][2:0] order_t;

  table_t          alloc_tbl, max_tbl;
  row_t            avail_vec;
  logic [3:0]      proc_reg;
  logic [2:0]      res_reg;
  result_t         expected_q[$];

  function automatic int procs_in_use();
    if (proc_reg == 0) return 1;
    if (proc_reg > PROCESS_SLOTS) return PROCESS_SLOTS;
    return proc_reg;
  endfunction

  function automatic int res_in_use();
    if (res_reg == 0) return 1;
    if (res_reg > RESOURCE_SLOTS) return RESOURCE_SLOTS;
    return res_reg;
  endfunction

  // repeated ascending passes, stop when all are finished or a pass finishes nothing
  function automatic bit safe_order(input table_t al, input row_t av,
                                    output order_t order, output int len);
    int w[RESOURCE_SLOTS];
    bit [PROCESS_SLOTS-1:0] done;
    bit progress, fits;
    int np, nr;
    np = procs_in_use();
    nr = res_in_use();
    order = '0;
    len = 0;
    done = '0;
    progress = 1;
    for (int r = 0; r < RESOURCE_SLOTS; r++) w[r] = av[r];
    while (len < np && progress) begin
      progress = 0;
      for (int p = 0; p < np; p++) begin
        if (!done[p]) begin
          fits = 1;
          for (int r = 0; r < nr; r++)
            if (int'(max_tbl[p][r]) - int'(al[p][r]) > w[r]) fits = 0;
          if (fits) begin
            for (int r = 0; r < nr; r++) w[r] += al[p][r];
            order[len] = p[2:0];
            len++;
            done[p] = 1;
            progress = 1;
          end
        end
      end
    end
    return len == np;
  endfunction

  function automatic void push_single(status_t st);
    result_t e;
    e.status = st;
    e.sequence_process = '0;
    e.last = 1'b1;
    expected_q.insert(expected_q.size(), e);
  endfunction

  function automatic void push_order(status_t st, order_t order, int len);
    result_t e;
    for (int k = 0; k < len; k++) begin
      e.status = st;
      e.sequence_process = order[k];
      e.last = (k + 1 == len);
      expected_q.insert(expected_q.size(), e);
    end
  endfunction

  function automatic void predict_transaction(item_t it);
    logic [7:0] req[RESOURCE_SLOTS];
    table_t tal;
    row_t tav;
    order_t order;
    int len, np, nr, pi, need;
    np = procs_in_use();
    nr = res_in_use();
    pi = it.process_index;
    req[0] = it.request_0;
    req[1] = it.request_1;
    req[2] = it.request_2;
    req[3] = it.request_3;
    case (it.operation)
      OP_LOAD_ALLOC: begin
        if (pi < np && it.resource_index < nr) alloc_tbl[pi][it.resource_index] = it.load_value;
        push_single(ST_LOADED);
      end
      OP_LOAD_MAX: begin
        if (pi < np && it.resource_index < nr) max_tbl[pi][it.resource_index] = it.load_value;
        push_single(ST_LOADED);
      end
      OP_LOAD_AVAIL: begin
        if (it.resource_index < nr) avail_vec[it.resource_index] = it.load_value;
        push_single(ST_LOADED);
      end
      OP_CHECK: begin
        if (safe_order(alloc_tbl, avail_vec, order, len)) push_order(ST_SAFE, order, len);
        else push_single(ST_UNSAFE);
      end
      OP_REQUEST: begin
        if (pi >= np) begin
          push_single(ST_EXCEEDS_NEED);
          return;
        end
        // need first, then available, resource by resource
        for (int r = 0; r < nr; r++) begin
          need = int'(max_tbl[pi][r]) - int'(alloc_tbl[pi][r]);
          if (int'(req[r]) > need) begin
            push_single(ST_EXCEEDS_NEED);
            return;
          end
          if (req[r] > avail_vec[r]) begin
            push_single(ST_UNAVAILABLE);
            return;
          end
        end
        tal = alloc_tbl;
        tav = avail_vec;
        for (int r = 0; r < nr; r++) begin
          tav[r] = tav[r] - req[r];
          tal[pi][r] = tal[pi][r] + req[r];
        end
        if (safe_order(tal, tav, order, len)) begin
          alloc_tbl = tal;
          avail_vec = tav;
          push_order(ST_GRANTED, order, len);
        end else begin
          push_single(ST_DENIED_UNSAFE);
        end
      end
      default: push_single(ST_LOADED);
    endcase
  endfunction

  task automatic report(string what, int exp_v, int got_v);
    $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, exp_v, got_v);
    errors++;
  endtask

  initial begin
    errors = 0;
    pending = 0;
    results_seen = 0;
  end

  always @(posedge clk) begin
    result_t e;
    if (rst) begin
      alloc_tbl = '0;
      max_tbl = '0;
      avail_vec = '0;
      proc_reg = 4'd8;
      res_reg = 3'd4;
      expected_q.delete();
    end else begin
      if (result_valid) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          report("unexpected result, status", -1, result.status);
        end else begin
          e = expected_q.pop_front();
          if (result.status !== e.status) report("status", e.status, result.status);
          if (result.sequence_process !== e.sequence_process)
            report("sequence_process", e.sequence_process, result.sequence_process);
          if (result.last !== e.last) report("last", e.last, result.last);
        end
      end
      if (cfg_we) begin
        if (cfg_index == REG_PROCESS_COUNT) proc_reg = cfg_data[3:0];
        else res_reg = cfg_data[2:0];
      end
      if (start && !busy) predict_transaction(item);
    end
    pending = expected_q.size();
  end

endmodule

// ----- sim/bankers_safety_and_request_tb.sv -----
// bankers_safety_and_request_tb: directed and random stimulus for the banker's unit
// over several count settings; depends on bsr_pkg, bsr_checker and the rtl top
`timescale 1ns / 100ps
module bankers_safety_and_request_tb;
  import bsr_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RANDOM_PER_PHASE = 37;
  localparam int CALM_TAIL = 40;  // last transactions get no random sender gaps

  logic                     clk;
  logic                     rst;
  logic                     start;
  logic                     busy;
  item_t                    item;
  logic                     result_valid;
  result_t                  result;
  logic                     cfg_we;
  logic                     cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  int errors, pending, results_seen;
  int accepted_cnt;
  int total_planned;
  int idle_cycles;

  // process and resource count per phase, extremes included (0 and 15 / 0 and 7)
  int phase_procs[7] = '{8, 3, 1, 15, 0, 5, 8};
  int phase_res[7]   = '{4, 2, 1, 7, 0, 3, 4};

  bankers_safety_and_request u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .result_valid(result_valid), .result(result),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  bsr_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .result_valid(result_valid), .result(result),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending), .results_seen(results_seen)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // watchdog: cycles with no transaction, no config write and no result
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d results pending", pending);
        $display("[bankers_safety_and_request] ERROR");
        $finish;
      end
    end
  end

  // one transaction: raise start at the falling edge, hold until accepted
  task automatic send(item_t it);
    @(negedge clk);
    item = it;
    start = 1'b1;
    do @(posedge clk); while (busy);
    accepted_cnt++;
    // random sender gaps except near the end of the run
    if (accepted_cnt < total_planned - CALM_TAIL && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      start = 1'b0;
      repeat ($urandom_range(0, 4)) @(negedge clk);
    end
  endtask

  task automatic drop_start();
    @(negedge clk);
    start = 1'b0;
  endtask

  // config writes only with nothing in flight
  task automatic write_reg(reg_idx_t idx, int value);
    drop_start();
    while (pending != 0 || busy) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = value[CFG_DATA_BITS-1:0];
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic item_t make_item(op_t op, int pi, int ri, int value,
                                      int r0, int r1, int r2, int r3);
    item_t it;
    it.operation = op;
    it.process_index = pi[2:0];
    it.resource_index = ri[1:0];
    it.load_value = value[7:0];
    it.request_0 = r0[7:0];
    it.request_1 = r1[7:0];
    it.request_2 = r2[7:0];
    it.request_3 = r3[7:0];
    return it;
  endfunction

  // mostly small counts so that safe states and grants are common
  function automatic int pick_count();
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 255);
    return $urandom_range(0, 12);
  endfunction

  function automatic item_t random_item();
    item_t it;
    int pick;
    it.process_index = $urandom_range(0, 7);
    it.resource_index = $urandom_range(0, 3);
    it.load_value = pick_count();
    it.request_0 = ($urandom_range(0, 1)) ? 0 : pick_count() % 6;
    it.request_1 = ($urandom_range(0, 1)) ? 0 : pick_count() % 6;
    it.request_2 = ($urandom_range(0, 1)) ? 0 : pick_count() % 6;
    it.request_3 = ($urandom_range(0, 1)) ? 0 : pick_count() % 6;
    if ($urandom_range(0, 15) == 0) it.request_2 = $urandom_range(0, 255);
    pick = $urandom_range(0, 99);
    if (pick < 14) it.operation = OP_LOAD_ALLOC;
    else if (pick < 30) it.operation = OP_LOAD_MAX;
    else if (pick < 44) begin
      it.operation = OP_LOAD_AVAIL;
      it.load_value = $urandom_range(0, 1) ? $urandom_range(0, 255) : pick_count() + 8;
    end
    else if (pick < 64) it.operation = OP_CHECK;
    else if (pick < 95) it.operation = OP_REQUEST;
    else it.operation = op_t'($urandom_range(5, 7));
    return it;
  endfunction

  initial begin
    rst = 1'b1;
    start = 1'b0;
    item = '0;
    cfg_we = 1'b0;
    cfg_index = REG_PROCESS_COUNT;
    cfg_data = '0;
    accepted_cnt = 0;
    idle_cycles = 0;
    total_planned = 20 + 7 * RANDOM_PER_PHASE;
    repeat (5) @(negedge clk);
    rst = 1'b0;

    // directed: full-scale entries, empty tables, every status except granted and unknown codes
    send(make_item(OP_CHECK, 0, 0, 0, 0, 0, 0, 0));
    send(make_item(OP_LOAD_MAX, 7, 3, 255, 0, 0, 0, 0));
    send(make_item(OP_LOAD_ALLOC, 7, 3, 255, 0, 0, 0, 0));
    send(make_item(OP_LOAD_MAX, 0, 0, 5, 0, 0, 0, 0));
    send(make_item(OP_REQUEST, 0, 0, 0, 3, 0, 0, 0));
    send(make_item(OP_LOAD_AVAIL, 0, 0, 2, 0, 0, 0, 0));
    send(make_item(OP_REQUEST, 0, 0, 0, 0, 1, 0, 0));
    send(make_item(OP_LOAD_MAX, 1, 0, 200, 0, 0, 0, 0));
    send(make_item(OP_CHECK, 0, 0, 0, 0, 0, 0, 0));
    send(make_item(OP_REQUEST, 0, 0, 0, 2, 0, 0, 0));
    send(make_item(OP_LOAD_MAX, 1, 0, 0, 0, 0, 0, 0));
    send(make_item(OP_REQUEST, 0, 0, 0, 2, 0, 0, 0));
    send(make_item(OP_LOAD_AVAIL, 3, 0, 255, 0, 0, 0, 0));
    send(make_item(OP_LOAD_MAX, 2, 3, 255, 0, 0, 0, 0));
    send(make_item(OP_REQUEST, 2, 0, 0, 0, 0, 0, 255));
    send(make_item(OP_CHECK, 0, 0, 0, 0, 0, 0, 0));
    send(make_item(op_t'(3'd5), 7, 3, 255, 255, 255, 255, 255));
    send(make_item(op_t'(3'd7), 0, 0, 0, 0, 0, 0, 0));
    send(make_item(OP_LOAD_ALLOC, 7, 3, 0, 0, 0, 0, 0));
    send(make_item(OP_CHECK, 0, 0, 0, 0, 0, 0, 0));

    for (int ph = 0; ph < 7; ph++) begin
      write_reg(REG_PROCESS_COUNT, phase_procs[ph]);
      write_reg(REG_RESOURCE_COUNT, phase_res[ph]);
      for (int n = 0; n < RANDOM_PER_PHASE; n++) send(random_item());
    end
    drop_start();

    // drain, then a short settle time
    while (pending != 0) @(negedge clk);
    repeat (50) @(negedge clk);

    $display("%0d transactions over 7 count settings, %0d results checked",
             accepted_cnt, results_seen);
    if (errors == 0) begin
      $display("[bankers_safety_and_request] OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("[bankers_safety_and_request] ERROR");
    end
    $finish;
  end

endmodule
